[rtl/rrqs_pkg.sv]
// ----------------------------------------------------------------------------
// rrqs_pkg
// Shared types and codes for the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
package rrqs_pkg;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned WORK_W  = 16;
  localparam int unsigned STAT_W  = 2;
  localparam logic [WORK_W-1:0] QUANTUM_RESET = 16'd4;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  localparam logic [STAT_W-1:0] ST_ADDED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RAN   = 2'd2;
  localparam logic [STAT_W-1:0] ST_IDLE  = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   job_id;
    logic [WORK_W-1:0] work_amount;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   served_id;
    logic [WORK_W-1:0] units_run;
    logic [WORK_W-1:0] work_left;
    logic              job_done;
    logic              ring_empty;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted input word
    logic read;    // read the head entry of the ring
    logic commit;  // update ring, pointers and output word
  } dp_cmd_t;

endpackage

[rtl/round_robin_quantum_scheduler.sv]
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler: time-slice job scheduler over a job ring
// Each accepted word passes capture, ring read and commit in turn; the ring head
// read is registered, and a stalled output holds the commit. No new word is
// accepted until the last one has been committed.
// Reset (rst_n, synchronous): ring emptied, pointers zero, quantum back to 4.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler
  import rrqs_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
)
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel: add a job or run one turn
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_word,
  // result channel: one word per input word
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word,
  // time quantum register
  input  logic              cfg_we,
  input  logic [WORK_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;

  // Controller: owns handshakes and the sequence capture -> read -> commit.
  rrqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath: ring memory, head/tail/count, quantum compare and subtract,
  // and the output register that holds a finished word until taken.
  rrqs_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_word  (out_word)
  );

endmodule

[rtl/rrqs_ctrl.sv]
// ----------------------------------------------------------------------------
// rrqs_ctrl
// Sequencer: accept a word, read the ring head, commit when the output is free.
// ----------------------------------------------------------------------------
module rrqs_ctrl
  import rrqs_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   commit;

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  // Commit only when the output register is empty or being drained.
  assign commit     = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.read   = (state_r == S_READ);
  assign cmd.commit = commit;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/rrqs_dp.sv]
// ----------------------------------------------------------------------------
// rrqs_dp
// Job ring storage, pointers, job count, quantum register and result word.
// ----------------------------------------------------------------------------
module rrqs_dp
  import rrqs_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 16
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  in_word_t          in_word,
  input  logic              cfg_we,
  input  logic [WORK_W-1:0] cfg_wdata,
  output out_word_t         out_word
);

  localparam int unsigned PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [ID_W-1:0]   id_mem   [RING_DEPTH];
  logic [WORK_W-1:0] work_mem [RING_DEPTH];

  in_word_t          item_r;
  logic [ID_W-1:0]   rd_id_r;
  logic [WORK_W-1:0] rd_work_r;
  logic [WORK_W-1:0] quantum_r;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  out_word_t         out_r, out_nxt;

  logic              wr_en;
  logic [ID_W-1:0]   wr_id;
  logic [WORK_W-1:0] wr_work;
  logic [PTR_W-1:0]  head_inc, tail_inc;

  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign tail_inc = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
  assign out_word = out_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_id     = item_r.job_id;
    wr_work   = item_r.work_amount;
    out_nxt   = '0;
    if (item_r.mode == MODE_ADD) begin
      if (count_r == CNT_FULL) begin
        out_nxt.status = ST_FULL;
      end else begin
        wr_en             = 1'b1;
        tail_nxt          = tail_inc;
        count_nxt         = count_r + CNT_ONE;
        out_nxt.status    = ST_ADDED;
        out_nxt.served_id = item_r.job_id;
        out_nxt.work_left = item_r.work_amount;
      end
    end else if (count_r == '0) begin
      out_nxt.status     = ST_IDLE;
      out_nxt.ring_empty = 1'b1;
    end else begin
      out_nxt.status    = ST_RAN;
      out_nxt.served_id = rd_id_r;
      head_nxt          = head_inc;
      if (rd_work_r > quantum_r) begin
        // Rotate: run one quantum, requeue the rest at the tail.
        wr_en             = 1'b1;
        wr_id             = rd_id_r;
        wr_work           = rd_work_r - quantum_r;
        tail_nxt          = tail_inc;
        out_nxt.units_run = quantum_r;
        out_nxt.work_left = rd_work_r - quantum_r;
      end else begin
        count_nxt          = count_r - CNT_ONE;
        out_nxt.units_run  = rd_work_r;
        out_nxt.job_done   = 1'b1;
        out_nxt.ring_empty = (count_r == CNT_ONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_id_r   <= id_mem[head_r];
      rd_work_r <= work_mem[head_r];
    end
    if (cmd.commit && wr_en) begin
      id_mem[tail_r]   <= wr_id;
      work_mem[tail_r] <= wr_work;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_word;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      quantum_r <= QUANTUM_RESET;
    end else begin
      if (cfg_we) begin
        quantum_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

[rtl/rrqs_checker.sv]
// ----------------------------------------------------------------------------
// rrqs_port_checker
// Port-level checks for the round-robin quantum scheduler.
// ----------------------------------------------------------------------------
module rrqs_port_checker
  import rrqs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in flight");

  a_done_only_on_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.job_done |-> out_word.status == ST_RAN)
    else $error("job completion flagged outside a turn");

  a_idle_run_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_IDLE |->
      out_word.ring_empty && out_word.served_id == '0 && out_word.units_run == '0)
    else $error("run on empty ring reported work");

endmodule

bind round_robin_quantum_scheduler rrqs_port_checker u_rrqs_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
